// ===== rtl/weekday_alarm_table_matcher_assert.svh =====
// Assertion macros shared by the alarm matcher. Each macro checks on the
// rising edge of clk and is switched off while rst_n is low.
`ifndef WEEKDAY_ALARM_TABLE_MATCHER_ASSERT_SVH
`define WEEKDAY_ALARM_TABLE_MATCHER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WAT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("alarm matcher: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define WAT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("alarm matcher: next-cycle check failed");

`endif

// ===== rtl/wat_pkg.sv =====
`default_nettype none

package wat_pkg;

    localparam int CMD_W    = 2;
    localparam int DAYS_W   = 8;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int DAY_W    = 3;
    localparam int IDX_W    = 4;
    localparam int COUNT_W  = 5;
    localparam int ENTRY_W  = DAYS_W + HOUR_W + MIN_W;

    // Bit of the day mask that marks a once-only entry.
    localparam int ONCE_BIT = 7;
    // Weekday codes run from 0 to this value minus one.
    localparam logic [DAY_W-1:0] DAYS_PER_WEEK = 3'd7;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic clear_cnt;
        logic append;
        logic reject;
        logic set_last;
        logic ptr_inc;
        logic rd_cur;
        logic rd_next;
        logic wr_shift;
        logic dec_cnt;
        logic fire;
    } wat_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_clear;
        logic is_append;
        logic is_tick;
        logic full;
        logic min_new;
        logic day_ok;
        logic scan_end;
        logic shift_end;
        logic match;
        logic once;
    } wat_stat_t;

endpackage

`default_nettype wire

// ===== rtl/wat_ctrl.sv =====
`default_nettype none

module wat_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire wat_pkg::wat_stat_t stat,
    output wat_pkg::wat_ctl_t      ctl,
    output logic                   busy,
    output logic                   done
);
    import wat_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg;
    logic   done_reg;
    logic   accept;

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;
    assign done   = done_reg;

    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        ctl.load   = accept;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = S_DONE;
                if (stat.is_clear) begin
                    ctl.clear_cnt = 1'b1;
                end else if (stat.is_append) begin
                    if (stat.full) begin
                        ctl.reject = 1'b1;
                    end else begin
                        ctl.append = 1'b1;
                    end
                end else if (stat.is_tick && stat.min_new) begin
                    ctl.set_last = 1'b1;
                    if (stat.day_ok) begin
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                if (stat.scan_end) begin
                    state_next = S_DONE;
                end else begin
                    ctl.rd_cur = 1'b1;
                    state_next = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (stat.match) begin
                    ctl.fire   = 1'b1;
                    state_next = stat.once ? S_SHIFT_RD : S_DONE;
                end else begin
                    ctl.ptr_inc = 1'b1;
                    state_next  = S_SCAN_RD;
                end
            end
            S_SHIFT_RD: begin
                if (stat.shift_end) begin
                    ctl.dec_cnt = 1'b1;
                    state_next  = S_DONE;
                end else begin
                    ctl.rd_next = 1'b1;
                    state_next  = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                ctl.wr_shift = 1'b1;
                ctl.ptr_inc  = 1'b1;
                state_next   = S_SHIFT_RD;
            end
            S_DONE: begin
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
            done_reg  <= (state_next == S_DONE);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/wat_datapath.sv =====
`default_nettype none

module wat_datapath #(
    parameter int MAX_ALARMS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire wat_pkg::wat_ctl_t             ctl,
    input  wire logic [wat_pkg::CMD_W-1:0]     command,
    input  wire logic [wat_pkg::DAYS_W-1:0]    alarm_days,
    input  wire logic [wat_pkg::HOUR_W-1:0]    alarm_hour,
    input  wire logic [wat_pkg::MIN_W-1:0]     alarm_minute,
    input  wire logic [wat_pkg::DAY_W-1:0]     now_day,
    input  wire logic [wat_pkg::HOUR_W-1:0]    now_hour,
    input  wire logic [wat_pkg::MIN_W-1:0]     now_minute,
    output wat_pkg::wat_stat_t                 stat,
    output logic                               fired,
    output logic [wat_pkg::IDX_W-1:0]          fired_index,
    output logic [wat_pkg::COUNT_W-1:0]        entry_count,
    output logic                               append_rejected
);
    import wat_pkg::*;

    localparam int CW = $clog2(MAX_ALARMS + 1);
    localparam int AW = (MAX_ALARMS > 1) ? $clog2(MAX_ALARMS) : 1;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ALARMS);

    logic [ENTRY_W-1:0] mem [MAX_ALARMS];

    logic [CW-1:0]      count_reg;
    logic [MIN_W-1:0]   last_min_reg;
    logic [CW-1:0]      ptr_reg;
    logic [ENTRY_W-1:0] rd_data_reg;

    logic [CMD_W-1:0]   cmd_reg;
    logic [DAYS_W-1:0]  a_days_reg;
    logic [HOUR_W-1:0]  a_hour_reg;
    logic [MIN_W-1:0]   a_min_reg;
    logic [DAY_W-1:0]   n_day_reg;
    logic [HOUR_W-1:0]  n_hour_reg;
    logic [MIN_W-1:0]   n_min_reg;
    logic               fired_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               reject_reg;

    logic [CW:0]        ptr_plus1;
    logic [DAYS_W-1:0]  rd_days;
    logic [HOUR_W-1:0]  rd_hour;
    logic [MIN_W-1:0]   rd_min;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               wr_en;

    assign ptr_plus1 = {1'b0, ptr_reg} + {{CW{1'b0}}, 1'b1};
    assign {rd_days, rd_hour, rd_min} = rd_data_reg;

    assign stat.is_clear  = (cmd_reg == CMD_CLEAR);
    assign stat.is_append = (cmd_reg == CMD_APPEND);
    assign stat.is_tick   = (cmd_reg == CMD_TICK);
    assign stat.full      = (count_reg >= MAX_CNT);
    assign stat.min_new   = (n_min_reg != last_min_reg);
    assign stat.day_ok    = (n_day_reg < DAYS_PER_WEEK);
    assign stat.scan_end  = (ptr_reg >= count_reg);
    assign stat.shift_end = (ptr_plus1 >= {1'b0, count_reg});
    assign stat.match     = rd_days[n_day_reg] && (rd_hour == n_hour_reg)
                            && (rd_min == n_min_reg);
    assign stat.once      = rd_days[ONCE_BIT];

    assign rd_addr = ctl.rd_next ? ptr_plus1[AW-1:0] : ptr_reg[AW-1:0];
    assign wr_en   = ctl.append || ctl.wr_shift;
    assign wr_addr = ctl.append ? count_reg[AW-1:0] : ptr_reg[AW-1:0];
    assign wr_data = ctl.append ? {a_days_reg, a_hour_reg, a_min_reg} : rd_data_reg;

    // Single-port style table: one write and one registered read per cycle.
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_cur || ctl.rd_next) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            count_reg    <= '0;
            last_min_reg <= '0;
        end else begin
            if (ctl.clear_cnt) begin
                count_reg <= '0;
            end else if (ctl.append) begin
                count_reg <= count_reg + CW'(1);
            end else if (ctl.dec_cnt) begin
                count_reg <= count_reg - CW'(1);
            end
            if (ctl.set_last) begin
                last_min_reg <= n_min_reg;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (ctl.load) begin
            cmd_reg    <= command;
            a_days_reg <= alarm_days;
            a_hour_reg <= alarm_hour;
            a_min_reg  <= alarm_minute;
            n_day_reg  <= now_day;
            n_hour_reg <= now_hour;
            n_min_reg  <= now_minute;
            ptr_reg    <= '0;
            fired_reg  <= 1'b0;
            idx_reg    <= '0;
            reject_reg <= 1'b0;
        end else begin
            if (ctl.ptr_inc) begin
                ptr_reg <= ptr_plus1[CW-1:0];
            end
            if (ctl.fire) begin
                fired_reg <= 1'b1;
                idx_reg   <= IDX_W'(ptr_reg);
            end
            if (ctl.reject) begin
                reject_reg <= 1'b1;
            end
        end
    end

    assign fired           = fired_reg;
    assign fired_index     = idx_reg;
    assign entry_count     = COUNT_W'(count_reg);
    assign append_rejected = reject_reg;

endmodule

`default_nettype wire

// ===== rtl/weekday_alarm_table_matcher.sv =====
`default_nettype none

// Weekday alarm table matcher. Raise start with a command while busy is low;
// the item is taken on that clock edge and busy stays high until its result
// has been shown. Every item gives exactly one result, presented on fired,
// fired_index, entry_count and append_rejected for the single cycle in which
// done is high. The receiver cannot stall the block, so the result must be
// captured in that cycle. A clear, an append, the unused code or a tick that
// does not scan goes from the decode state straight to the done state. A
// time tick that starts a scan reads and compares each entry in turn (scan
// read, scan compare) until one matches or the entries run out; when a
// once-only entry is removed, each later entry is then read and written one
// place down (shift read, shift write) until the shift ends. The item ends
// in the done state. The alarm table has one registered read and one write
// per cycle, so the scan and the shift go one entry at a time.
// A new item may be started in the cycle after done.
module weekday_alarm_table_matcher #(
    parameter int MAX_ALARMS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [wat_pkg::CMD_W-1:0]     command,
    input  wire logic [wat_pkg::DAYS_W-1:0]    alarm_days,
    input  wire logic [wat_pkg::HOUR_W-1:0]    alarm_hour,
    input  wire logic [wat_pkg::MIN_W-1:0]     alarm_minute,
    input  wire logic [wat_pkg::DAY_W-1:0]     now_day,
    input  wire logic [wat_pkg::HOUR_W-1:0]    now_hour,
    input  wire logic [wat_pkg::MIN_W-1:0]     now_minute,
    output logic                               done,
    output logic                               fired,
    output logic [wat_pkg::IDX_W-1:0]          fired_index,
    output logic [wat_pkg::COUNT_W-1:0]        entry_count,
    output logic                               append_rejected
);
    import wat_pkg::*;

    `include "weekday_alarm_table_matcher_assert.svh"

    // Command and status buses between the sequencer and the table datapath.
    wat_ctl_t  ctl;
    wat_stat_t stat;

    // The sequencer decodes each item, walks the table one entry at a time
    // and, for a once-only hit, moves the later entries down one place.
    wat_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    // The datapath holds the alarm table, the entry count, the last minute
    // acted on and the result registers.
    wat_datapath #(
        .MAX_ALARMS (MAX_ALARMS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .command         (command),
        .alarm_days      (alarm_days),
        .alarm_hour      (alarm_hour),
        .alarm_minute    (alarm_minute),
        .now_day         (now_day),
        .now_hour        (now_hour),
        .now_minute      (now_minute),
        .stat            (stat),
        .fired           (fired),
        .fired_index     (fired_index),
        .entry_count     (entry_count),
        .append_rejected (append_rejected)
    );

    // A result is only ever shown while an item is in flight.
    `WAT_ASSERT_NOW(a_done_while_busy, done, busy)
    // The result strobe lasts one cycle and the block is then free.
    `WAT_ASSERT_NEXT(a_done_single, done, !done && !busy)
    // An accepted item keeps the block busy in the following cycle.
    `WAT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // An item cannot both fire an alarm and be a rejected append.
    `WAT_ASSERT_NOW(a_fire_xor_reject, done, !(fired && append_rejected))

endmodule

`default_nettype wire

// ===== tb/tb_weekday_alarm_table_matcher.sv =====
`default_nettype none

module tb_weekday_alarm_table_matcher;

    timeunit 1ns;
    timeprecision 1ps;

    import wat_pkg::*;

    localparam int MAX_ALARMS   = 16;
    localparam int RANDOM_ITEMS = 600;
    // Command code 3 has no meaning; the block must leave its state alone.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // One result as the block presents it during its done cycle.
    typedef struct packed {
        logic               fired;
        logic [IDX_W-1:0]   index;
        logic [COUNT_W-1:0] count;
        logic               rejected;
    } alarm_result_t;

    // The scoreboard keeps its own copy of the alarm table. Every accepted item
    // is applied to that copy right away, and the result it should produce is
    // queued. Results from the block are then matched in order against it.
    class alarm_scoreboard;
        logic [DAYS_W-1:0] days_tab [MAX_ALARMS];
        logic [HOUR_W-1:0] hour_tab [MAX_ALARMS];
        logic [MIN_W-1:0]  min_tab  [MAX_ALARMS];
        int                used;
        logic [MIN_W-1:0]  last_min;
        alarm_result_t     expected_results [$];
        int                errors;

        function new();
            used     = 0;
            last_min = '0;
            errors   = 0;
        endfunction

        // Applies one accepted item to the table copy and queues its result.
        function void note_item(input logic [CMD_W-1:0] cmd,
                                input logic [DAYS_W-1:0] a_days,
                                input logic [HOUR_W-1:0] a_hour,
                                input logic [MIN_W-1:0] a_min,
                                input logic [DAY_W-1:0] n_day,
                                input logic [HOUR_W-1:0] n_hour,
                                input logic [MIN_W-1:0] n_min);
            alarm_result_t r;
            r = '0;
            case (cmd)
                CMD_CLEAR: used = 0;
                CMD_APPEND:
                begin
                    if (used >= MAX_ALARMS)
                    begin
                        r.rejected = 1'b1;
                    end
                    else
                    begin
                        days_tab[used] = a_days;
                        hour_tab[used] = a_hour;
                        min_tab[used]  = a_min;
                        used++;
                    end
                end
                CMD_TICK:
                begin
                    if (n_min != last_min)
                    begin
                        last_min = n_min;
                        if (n_day < DAYS_PER_WEEK)
                        begin
                            for (int i = 0; i < used && !r.fired; i++)
                            begin
                                if (days_tab[i][n_day] && hour_tab[i] == n_hour &&
                                    min_tab[i] == n_min)
                                begin
                                    r.fired = 1'b1;
                                    r.index = i[IDX_W-1:0];
                                    if (days_tab[i][ONCE_BIT])
                                    begin
                                        for (int k = i; k + 1 < used; k++)
                                        begin
                                            days_tab[k] = days_tab[k+1];
                                            hour_tab[k] = hour_tab[k+1];
                                            min_tab[k]  = min_tab[k+1];
                                        end
                                        used--;
                                    end
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
            r.count = used[COUNT_W-1:0];
            expected_results = {expected_results, r};
        endfunction

        function void compare_field(input string name, input int unsigned want,
                                    input int unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(input alarm_result_t got);
            alarm_result_t want;
            if (expected_results.size() == 0)
            begin
                $error("result with no item waiting for it");
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                compare_field("fired", 32'(want.fired), 32'(got.fired));
                compare_field("fired_index", 32'(want.index), 32'(got.index));
                compare_field("entry_count", 32'(want.count), 32'(got.count));
                compare_field("append_rejected", 32'(want.rejected),
                              32'(got.rejected));
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [CMD_W-1:0]   command;
    logic [DAYS_W-1:0]  alarm_days;
    logic [HOUR_W-1:0]  alarm_hour;
    logic [MIN_W-1:0]   alarm_minute;
    logic [DAY_W-1:0]   now_day;
    logic [HOUR_W-1:0]  now_hour;
    logic [MIN_W-1:0]   now_minute;
    logic               done;
    logic               fired;
    logic [IDX_W-1:0]   fired_index;
    logic [COUNT_W-1:0] entry_count;
    logic               append_rejected;

    alarm_scoreboard sb = new();
    // While this is above zero the sender issues items back to back.
    int              burst_left = 0;

    weekday_alarm_table_matcher #(
        .MAX_ALARMS (MAX_ALARMS)
    ) DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .command         (command),
        .alarm_days      (alarm_days),
        .alarm_hour      (alarm_hour),
        .alarm_minute    (alarm_minute),
        .now_day         (now_day),
        .now_hour        (now_hour),
        .now_minute      (now_minute),
        .done            (done),
        .fired           (fired),
        .fired_index     (fired_index),
        .entry_count     (entry_count),
        .append_rejected (append_rejected)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Results cannot be held off, so every done cycle is taken as it comes.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            sb.check_result('{fired, fired_index, entry_count, append_rejected});
        end
    end

    // Most gaps are short, some are medium, a few are long. During a burst
    // there is no gap at all, so the block sees start held high for many items.
    function automatic int pick_gap();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Presents one item at the falling edge and holds it until a rising edge
    // finds busy low. The item is noted at that edge, before its result can
    // appear. During a gap between items the fields are filled with noise.
    task automatic send_item(input logic [CMD_W-1:0] cmd,
                             input logic [DAYS_W-1:0] a_days,
                             input logic [HOUR_W-1:0] a_hour,
                             input logic [MIN_W-1:0] a_min,
                             input logic [DAY_W-1:0] n_day,
                             input logic [HOUR_W-1:0] n_hour,
                             input logic [MIN_W-1:0] n_min);
        int gap;
        @(negedge clk);
        start        = 1'b1;
        command      = cmd;
        alarm_days   = a_days;
        alarm_hour   = a_hour;
        alarm_minute = a_min;
        now_day      = n_day;
        now_hour     = n_hour;
        now_minute   = n_min;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_item(cmd, a_days, a_hour, a_min, n_day, n_hour, n_min);
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            start        = 1'b0;
            command      = CMD_W'($urandom);
            alarm_days   = DAYS_W'($urandom);
            alarm_hour   = HOUR_W'($urandom);
            alarm_minute = MIN_W'($urandom);
            now_day      = DAY_W'($urandom);
            now_hour     = HOUR_W'($urandom);
            now_minute   = MIN_W'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // The fields that belong to other commands always carry random values,
    // since the block has to ignore them.
    task automatic append_alarm(input logic [DAYS_W-1:0] days,
                                input logic [HOUR_W-1:0] hour,
                                input logic [MIN_W-1:0] minute);
        send_item(CMD_APPEND, days, hour, minute, DAY_W'($urandom),
                  HOUR_W'($urandom), MIN_W'($urandom));
    endtask

    task automatic time_tick(input logic [DAY_W-1:0] day,
                             input logic [HOUR_W-1:0] hour,
                             input logic [MIN_W-1:0] minute);
        send_item(CMD_TICK, DAYS_W'($urandom), HOUR_W'($urandom), MIN_W'($urandom),
                  day, hour, minute);
    endtask

    task automatic bare_command(input logic [CMD_W-1:0] cmd);
        send_item(cmd, DAYS_W'($urandom), HOUR_W'($urandom), MIN_W'($urandom),
                  DAY_W'($urandom), HOUR_W'($urandom), MIN_W'($urandom));
    endtask

    // Aims a tick at a table entry (random if the table is empty): a day of
    // its mask if any, its hour and its minute. If that minute is the last one
    // seen, a tick on another minute goes first so the aimed tick is acted on.
    task automatic tick_at_entry();
        int                pos;
        int                d;
        logic [DAY_W-1:0]  day;
        if (sb.used == 0)
        begin
            time_tick(DAY_W'($urandom_range(0, 6)), HOUR_W'($urandom_range(0, 23)),
                      MIN_W'($urandom_range(0, 59)));
        end
        else
        begin
            pos = $urandom_range(0, sb.used - 1);
            d   = $urandom_range(0, 6);
            day = d[DAY_W-1:0];
            for (int k = 0; k < 7; k++)
            begin
                if (sb.days_tab[pos][(d + k) % 7])
                begin
                    day = DAY_W'((d + k) % 7);
                    break;
                end
            end
            if (sb.min_tab[pos] == sb.last_min)
            begin
                time_tick(DAY_W'($urandom), HOUR_W'($urandom),
                          sb.min_tab[pos] ^ 6'd1);
            end
            time_tick(day, sb.hour_tab[pos], sb.min_tab[pos]);
        end
    endtask

    initial
    begin
        int               pick;
        logic [DAYS_W-1:0] days;

        rst_n        = 1'b0;
        start        = 1'b0;
        command      = CMD_CLEAR;
        alarm_days   = '0;
        alarm_hour   = '0;
        alarm_minute = '0;
        now_day      = '0;
        now_hour     = '0;
        now_minute   = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. The stored last minute starts at zero, so a first
        // tick on minute zero must not scan.
        time_tick(3'd0, 5'd0, 6'd0);
        bare_command(CMD_UNUSED);
        append_alarm(8'hFF, 5'd31, 6'd63);
        append_alarm(8'h00, 5'd0, 6'd0);
        append_alarm(8'h81, 5'd5, 6'd10);
        append_alarm(8'h7F, 5'd23, 6'd59);
        // A once-only Sunday entry fires at index 2 and is removed.
        time_tick(3'd0, 5'd5, 6'd10);
        // The same minute again must not scan.
        time_tick(3'd0, 5'd5, 6'd10);
        // Weekday 7 matches nothing, even an entry with every mask bit set.
        time_tick(3'd7, 5'd31, 6'd63);
        time_tick(3'd6, 5'd31, 6'd62);
        // The all-ones entry is once-only as well and leaves the table.
        time_tick(3'd6, 5'd31, 6'd63);
        // A repeating entry fires and stays.
        time_tick(3'd6, 5'd23, 6'd59);
        // Fill the table. The fillers never carry Saturday, so of the new entries
        // only the one in the last slot can be hit by a Saturday tick.
        repeat (MAX_ALARMS - 3) append_alarm(DAYS_W'($urandom) & 8'hBF,
                                             HOUR_W'($urandom), MIN_W'($urandom));
        append_alarm(8'h40, 5'd12, 6'd30);
        // The table is full now, so this append is turned away.
        append_alarm(8'h80, 5'd1, 6'd1);
        time_tick(3'd6, 5'd12, 6'd30);
        // Clear keeps the last minute, so the tick after it must not scan.
        bare_command(CMD_CLEAR);
        time_tick(3'd6, 5'd12, 6'd30);

        // Random part. Most items append entries and aim ticks at them, so
        // that matches, removals and shifts happen often. The rest is random
        // ticks across the full field ranges, clears and the unused code.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if ($urandom_range(0, 99) == 0) burst_left = 30;
            pick = $urandom_range(0, 99);
            if (pick < 5)
            begin
                bare_command(CMD_CLEAR);
            end
            else if (pick < 7)
            begin
                bare_command(CMD_UNUSED);
            end
            else if (pick < 40)
            begin
                case ($urandom_range(0, 9))
                    0:       days = 8'hFF;
                    1:       days = 8'h00;
                    default: days = DAYS_W'($urandom);
                endcase
                if ($urandom_range(0, 4) == 0)
                begin
                    append_alarm(days, HOUR_W'($urandom), MIN_W'($urandom));
                end
                else
                begin
                    append_alarm(days, HOUR_W'($urandom_range(0, 23)),
                                 MIN_W'($urandom_range(0, 59)));
                end
            end
            else if (pick < 82)
            begin
                tick_at_entry();
            end
            else
            begin
                time_tick(DAY_W'($urandom), HOUR_W'($urandom), MIN_W'($urandom));
            end
        end

        @(negedge clk);
        start = 1'b0;
        while (sb.expected_results.size() != 0) @(posedge clk);
        // Any stray result would show within one scan time of the last one.
        repeat (4 * MAX_ALARMS + 20) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    // A correct run needs well under a millisecond of simulated time.
    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/wat_pkg.sv
rtl/wat_ctrl.sv
rtl/wat_datapath.sv
rtl/weekday_alarm_table_matcher.sv
tb/tb_weekday_alarm_table_matcher.sv
